[hdl/rvrr_pkg.sv]
// rvrr_pkg: item types, field codes and status codes for the relocation resolver.
// Used by rvrr_patch and rv32_relocation_resolver; depends on nothing.
package rvrr_pkg;

  // input item: define or fixup
  typedef struct packed {
    logic               action;
    logic [7:0]         label_index;
    logic [1:0]         label_section;
    logic [23:0]        label_offset;
    logic [2:0]         fix_kind;
    logic signed [31:0] addend;
    logic [23:0]        patch_offset;
    logic [31:0]        insn_word;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [31:0] patched_word;
    logic [1:0]  status;
  } out_item_t;

  // action codes
  localparam logic ACT_DEFINE = 1'b0;
  localparam logic ACT_FIXUP  = 1'b1;

  // section codes
  localparam logic [1:0] SEC_TEXT  = 2'd0;
  localparam logic [1:0] SEC_DATA  = 2'd1;
  localparam logic [1:0] SEC_BSS   = 2'd2;
  localparam logic [1:0] SEC_IMAGE = 2'd3;

  // fixup kinds
  localparam logic [2:0] KIND_ABS32  = 3'd0;
  localparam logic [2:0] KIND_JAL    = 3'd1;
  localparam logic [2:0] KIND_BRANCH = 3'd2;
  localparam logic [2:0] KIND_HI20   = 3'd3;
  localparam logic [2:0] KIND_LO12_I = 3'd4;
  localparam logic [2:0] KIND_LO12_S = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_JAL_RANGE = 2'd1;
  localparam logic [1:0] STAT_BR_RANGE  = 2'd2;
  localparam logic [1:0] STAT_UNPLACED  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_CODE_ORG  = 2'd0;
  localparam logic [1:0] CFG_INIT_ORG  = 2'd1;
  localparam logic [1:0] CFG_ZERO_ORG  = 2'd2;
  localparam logic [1:0] CFG_IMAGE_END = 2'd3;

  localparam logic [31:0] RESET_BASE = 32'h8000_0000;

  // control mode of the top level
  typedef enum logic {
    MODE_CLEAR,
    MODE_RUN
  } mode_t;

  // resolved fixup handed to the patch stage
  typedef struct packed {
    logic        action;
    logic        placed;
    logic [2:0]  kind;
    logic [31:0] target;
    logic [31:0] pc;
    logic [31:0] insn;
  } resolved_t;

endpackage

[hdl/rv32_relocation_resolver.sv]
// rv32_relocation_resolver: label table and fixup resolution for RV32 code.
// Each accepted item passes through the stage-one registers, stage two and the result register.
// Throughput: one item per cycle while result_stall is low; the label table has separate read and write ports.
// Reset: base registers return to 0x80000000, then a clearing pass over all LABEL_COUNT
// entries marks every label unplaced; items are held off during the pass.
// Depends on rvrr_pkg and rvrr_patch.
module rv32_relocation_resolver
  import rvrr_pkg::*;
#(
  parameter int LABEL_COUNT = 256,
  parameter int OFFSET_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(LABEL_COUNT);
  localparam int EW = 3 + OFFSET_BITS;

  // configuration registers
  logic [31:0] code_org;
  logic [31:0] init_org;
  logic [31:0] zero_org;
  logic [31:0] image_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_org  <= RESET_BASE;
      init_org  <= RESET_BASE;
      zero_org  <= RESET_BASE;
      image_end <= RESET_BASE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODE_ORG:  code_org  <= cfg_data;
        CFG_INIT_ORG:  init_org  <= cfg_data;
        CFG_ZERO_ORG:  zero_org  <= cfg_data;
        CFG_IMAGE_END: image_end <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass control
  mode_t       mode;
  mode_t       mode_next;
  logic [AW-1:0] clr_cnt;
  logic        clr_last;

  assign clr_last = (clr_cnt == AW'(LABEL_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_CLEAR;
      clr_cnt <= '0;
    end else begin
      mode <= mode_next;
      if (mode == MODE_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_CLEAR: if (clr_last) mode_next = MODE_RUN;
      MODE_RUN:   mode_next = MODE_RUN;
      default:    mode_next = MODE_CLEAR;
    endcase
  end

  // pipeline handshake
  logic s1_valid;
  logic s2_valid;
  logic adv1;
  logic adv2;
  logic accept;

  assign adv2       = !result_valid || !result_stall;
  assign adv1       = !s2_valid || adv2;
  assign item_stall = (mode == MODE_CLEAR) || (s1_valid && !adv1);
  assign accept     = item_valid && !item_stall;

  // index and offsets reduced to table and offset widths
  logic [31:0]          idx_wide;
  logic [AW-1:0]        idx_addr;
  logic                 idx_ok;
  logic [31:0]          lofs_wide;
  logic [31:0]          pofs_wide;
  logic [OFFSET_BITS-1:0] pofs_m;

  assign idx_wide  = 32'(item.label_index);
  assign idx_addr  = idx_wide[AW-1:0];
  assign idx_ok    = (idx_wide < 32'(LABEL_COUNT));
  assign lofs_wide = 32'(item.label_offset);
  assign pofs_wide = 32'(item.patch_offset);
  assign pofs_m    = pofs_wide[OFFSET_BITS-1:0];

  // label table: {placed, section, offset}
  logic [EW-1:0] table_mem [LABEL_COUNT];
  logic [EW-1:0] rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_addr;
    mem_wdata = {1'b1, item.label_section, lofs_wide[OFFSET_BITS-1:0]};
    if (mode == MODE_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (accept && item.action == ACT_DEFINE && idx_ok) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
  end

  // read on accept only, so the entry holds while stage one is stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= table_mem[idx_addr];
    end
  end

  // stage one: item fields and the pc of the patched word
  logic        s1_action;
  logic        s1_idx_ok;
  logic [2:0]  s1_kind;
  logic [31:0] s1_addend;
  logic [31:0] s1_pc;
  logic [31:0] s1_insn;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= item.action;
      s1_idx_ok <= idx_ok;
      s1_kind   <= item.fix_kind;
      s1_addend <= item.addend;
      s1_pc     <= code_org + 32'(pofs_m);
      s1_insn   <= item.insn_word;
    end
  end

  // stage two: label address plus addend
  logic                   ent_placed;
  logic [1:0]             ent_sec;
  logic [OFFSET_BITS-1:0] ent_ofs;
  logic [31:0]            add_base;
  logic [31:0]            add_ofs;
  resolved_t              s2;

  assign {ent_placed, ent_sec, ent_ofs} = rd_data;

  always_comb begin
    add_ofs = 32'(ent_ofs);
    case (ent_sec)
      SEC_TEXT:  add_base = code_org;
      SEC_DATA:  add_base = init_org;
      SEC_BSS:   add_base = zero_org;
      SEC_IMAGE: begin
        add_base = image_end;
        add_ofs  = 32'd0;
      end
      default:   add_base = image_end;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_valid && adv1) begin
      s2.action <= s1_action;
      s2.placed <= ent_placed && s1_idx_ok;
      s2.kind   <= s1_kind;
      s2.target <= add_base + add_ofs + s1_addend;
      s2.pc     <= s1_pc;
      s2.insn   <= s1_insn;
    end
  end

  // stage three: patch into the output register
  out_item_t patch_res;

  rvrr_patch u_patch (
    .fix (s2),
    .res (patch_res)
  );

  always_ff @(posedge clk) begin
    if (s2_valid && adv2) begin
      result <= patch_res;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv1) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && adv1) begin
        s2_valid <= 1'b1;
      end else if (adv2) begin
        s2_valid <= 1'b0;
      end
      if (s2_valid && adv2) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // no item enters while the table is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_CLEAR) |-> item_stall)
    else $error("item accepted during clearing pass");

  // an accepted item occupies stage one next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item lost before stage one");

  // a stalled stage one keeps its table entry
  a_entry_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv1) |=> (s1_valid && $stable(rd_data)))
    else $error("table entry changed under a stalled item");

  // table writes come only from the clearing pass or a define item
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mode == MODE_RUN) |-> (accept && item.action == ACT_DEFINE))
    else $error("unexpected label table write");

endmodule

[hdl/rvrr_patch.sv]
// rvrr_patch: pc-relative range checks and immediate scattering into the word.
// Depends on rvrr_pkg (resolved_t, out_item_t, kind and status codes).
module rvrr_patch
  import rvrr_pkg::*;
(
  input  resolved_t fix,
  output out_item_t res
);

  logic [31:0] rel;
  logic [19:0] hi20;
  logic        jal_ok;
  logic        br_ok;

  // displacement from the patched word and the rounded upper part
  assign rel  = fix.target - fix.pc;
  assign hi20 = fix.target[31:12] + {19'd0, fix.target[11]};

  // in range when the upper bits are a pure sign extension
  assign jal_ok = (rel[31:20] == 12'h000) || (rel[31:20] == 12'hfff);
  assign br_ok  = (rel[31:12] == 20'h00000) || (rel[31:12] == 20'hfffff);

  always_comb begin
    res.patched_word = fix.insn;
    res.status       = STAT_OK;
    if (fix.action == ACT_DEFINE) begin
      res.patched_word = 32'd0;
    end else if (!fix.placed) begin
      res.status = STAT_UNPLACED;
    end else begin
      case (fix.kind)
        KIND_ABS32: begin
          res.patched_word = fix.target;
        end
        KIND_JAL: begin
          if (jal_ok) begin
            res.patched_word = {rel[20], rel[10:1], rel[11], rel[19:12], fix.insn[11:0]};
          end else begin
            res.status = STAT_JAL_RANGE;
          end
        end
        KIND_BRANCH: begin
          if (br_ok) begin
            res.patched_word = {rel[12], rel[10:5], fix.insn[24:12], rel[4:1], rel[11],
                                fix.insn[6:0]};
          end else begin
            res.status = STAT_BR_RANGE;
          end
        end
        KIND_HI20: begin
          res.patched_word = {hi20, fix.insn[11:0]};
        end
        KIND_LO12_I: begin
          res.patched_word = {fix.target[11:0], fix.insn[19:0]};
        end
        KIND_LO12_S: begin
          res.patched_word = {fix.target[11:5], fix.insn[24:12], fix.target[4:0],
                              fix.insn[6:0]};
        end
        default: begin
          // undefined kinds pass the word through
          res.patched_word = fix.insn;
        end
      endcase
    end
  end

endmodule
